@@ hdl/crse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crse_pkg - shared types and constants of the Catmull-Rom spline evaluator
// Field widths, command and status codes, and the control word that steers
// the per-axis datapath.
// ----------------------------------------------------------------------------
package crse_pkg;

   // Fixed field widths
   localparam int POINT_W   = 16;
   localparam int SEG_W     = 6;
   localparam int FRAC_IN_W = 12;
   localparam int STATUS_W  = 2;

   // Four control points per segment
   localparam int TAPS      = 4;
   localparam int TAP_IDX_W = 2;

   // Command codes
   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_EVAL   = 1'b1;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // Load control for the axis datapath: shift in one point, flag the last one
   typedef struct packed {
      logic shift;
      logic last;
   } shift_ctrl_type;

endpackage : crse_pkg
`default_nettype wire

@@ hdl/crse_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crse_store - single-port control point memory
// One access per cycle, read or write; read data is registered.
// ----------------------------------------------------------------------------
module crse_store #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [DATA_W-1:0] wdata,
   output logic      [DATA_W-1:0] rdata
);
   import crse_pkg::*;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // Write or read one entry
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule : crse_store
`default_nettype wire

@@ hdl/crse_axis.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crse_axis - Catmull-Rom evaluation of one coordinate axis
// Collects four points, forms the basis coefficients, then runs Horner's
// rule over three multiply stages, rounds and saturates.
// ----------------------------------------------------------------------------
module crse_axis #(
   parameter int FRACTION_BITS = 12
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire crse_pkg::shift_ctrl_type            ctrl,
   input  wire logic signed [crse_pkg::POINT_W-1:0] word,
   input  wire logic        [FRACTION_BITS-1:0]     frac,
   output logic signed      [crse_pkg::POINT_W-1:0] result,
   output logic                                     done
);
   import crse_pkg::*;

   localparam int FB    = FRACTION_BITS;
   localparam int COEF_W = 20;             // holds 12 * 2^15
   localparam int H1_W  = COEF_W + FB + 1;
   localparam int H2_W  = H1_W + FB + 1;
   localparam int T_W   = H2_W + FB + 1;
   localparam int V_W   = T_W - (3 * FB + 1);

   logic signed [POINT_W-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [COEF_W-1:0]  e0, e1, e2, e3;
   logic signed [COEF_W-1:0]  a_ff, b_ff, c_ff, d_ff;
   logic signed [COEF_W-1:0]  a1_ff, a2_ff, b1_ff;
   logic signed [FB:0]        fs;
   logic signed [H1_W-1:0]    prod1, h1_in, h1_ff;
   logic signed [H2_W-1:0]    prod2, h2_in, h2_ff;
   logic signed [T_W-1:0]     prod3, t_in, t_ff;
   logic signed [V_W-1:0]     v;
   logic signed [POINT_W-1:0] result_in, result_ff;
   logic [5:0]                vld_ff;

   // Shift points in; the first one read ends up in p0
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         p0_ff <= p1_ff;
         p1_ff <= p2_ff;
         p2_ff <= p3_ff;
         p3_ff <= word;
      end
   end

   // Basis coefficients
   assign e0 = COEF_W'(p0_ff);
   assign e1 = COEF_W'(p1_ff);
   assign e2 = COEF_W'(p2_ff);
   assign e3 = COEF_W'(p3_ff);
   assign fs = signed'({1'b0, frac});

   always_ff @(posedge clock) begin
      a_ff <= e1 <<< 1;
      b_ff <= e2 - e0;
      c_ff <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      d_ff <= (e1 <<< 1) + e1 - e0 - (e2 <<< 1) - e2 + e3;
   end

   // Horner: h1 = d f + c one, h2 = h1 f + b one^2, t = h2 f + (a+1) one^3
   assign prod1 = d_ff * fs;
   assign h1_in = prod1 + (H1_W'(c_ff) <<< FB);
   assign prod2 = h1_ff * fs;
   assign h2_in = prod2 + (H2_W'(b1_ff) <<< (2 * FB));
   assign prod3 = h2_ff * fs;
   assign t_in  = prod3 + ((T_W'(a2_ff) + T_W'(1)) <<< (3 * FB));

   always_ff @(posedge clock) begin
      h1_ff <= h1_in;
      b1_ff <= b_ff;
      a1_ff <= a_ff;
      h2_ff <= h2_in;
      a2_ff <= a1_ff;
      t_ff  <= t_in;
   end

   // Halve and floor, then clamp to 16 bits
   assign v = t_ff[T_W-1:3*FB+1];

   always_comb begin
      if ((&v[V_W-1:POINT_W-1]) || !(|v[V_W-1:POINT_W-1])) begin
         result_in = v[POINT_W-1:0];
      end else if (v[V_W-1]) begin
         result_in = {1'b1, {(POINT_W-1){1'b0}}};
      end else begin
         result_in = {1'b0, {(POINT_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   // Advance stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[4:0], ctrl.shift & ctrl.last};
      end
   end

   assign result = result_ff;
   assign done   = vld_ff[5];

endmodule : crse_axis
`default_nettype wire

@@ hdl/catmull_rom_spline_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// catmull_rom_spline_eval - uniform Catmull-Rom spline evaluator
// Append 2-D control points and evaluate the curve at segment + fraction.
// ----------------------------------------------------------------------------
// Append words write one point into a single-port store and then answer. An
// evaluate word reads its four points from that store, one per cycle, and
// then runs both axes through a five-stage multiply pipeline; the single
// memory port and the three chained multiplies set its latency. One word
// is in work at a time, but a new word is taken while the previous result
// waits on rsp. Status: 0 ok, 1 store full (append dropped), 2 segment out
// of range; the curve outputs are zero unless an evaluate succeeded.
// Results are rounded to nearest (halves up) and saturated to 16 bits.
// ----------------------------------------------------------------------------
module catmull_rom_spline_eval #(
   parameter int MAX_POINTS    = 64,
   parameter int FRACTION_BITS = 12
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_command,
   input  wire logic signed [crse_pkg::POINT_W-1:0]    req_point_x,
   input  wire logic signed [crse_pkg::POINT_W-1:0]    req_point_y,
   input  wire logic        [crse_pkg::SEG_W-1:0]      req_segment,
   input  wire logic        [crse_pkg::FRAC_IN_W-1:0]  req_fraction,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed      [crse_pkg::POINT_W-1:0]    rsp_curve_x,
   output logic signed      [crse_pkg::POINT_W-1:0]    rsp_curve_y,
   output logic             [crse_pkg::STATUS_W-1:0]   rsp_status
);
   import crse_pkg::*;

   localparam int FB      = FRACTION_BITS;
   localparam int ADDR_W  = $clog2(MAX_POINTS);
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int CMP_W   = (CNT_W > SEG_W + 1) ? CNT_W : SEG_W + 1;
   localparam int SUM_W   = ((ADDR_W > SEG_W) ? ADDR_W : SEG_W) + 1;
   localparam int FEXT_W  = (FB > FRAC_IN_W) ? FB : FRAC_IN_W;
   localparam int WORD_W  = 2 * POINT_W;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_CALC = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SEG_W-1:0]        seg_ff;
   logic [FB-1:0]           frac_ff;
   logic [FEXT_W-1:0]       frac_ext;
   logic [TAP_IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                    rd_valid_ff, rd_last_ff;
   status_type              pend_status_ff, pend_status_in;
   logic                    pend_eval_ff, pend_eval_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [POINT_W-1:0] rsp_curve_x_ff, rsp_curve_y_ff;
   status_type              rsp_status_ff;
   logic                    req_accept, store_full, seg_ok, slot_free, rsp_load;
   logic [CMP_W-1:0]        seg_end;
   logic [SUM_W-1:0]        rd_sum;
   logic                    store_en, store_we;
   logic [ADDR_W-1:0]       store_addr;
   logic [WORD_W-1:0]       store_rdata;
   shift_ctrl_type          shift_ctrl;
   logic signed [POINT_W-1:0] x_result, y_result;
   logic                    x_done, y_done;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid & req_ready;
   assign store_full = (cnt_ff == CNT_W'(MAX_POINTS));
   assign seg_end    = CMP_W'(req_segment) + CMP_W'(TAPS - 1);
   assign seg_ok     = (seg_end < CMP_W'(cnt_ff));
   assign slot_free  = ~rsp_valid_ff | rsp_ready;
   assign frac_ext   = FEXT_W'(req_fraction);
   assign rd_sum     = SUM_W'(seg_ff) + SUM_W'(rd_idx_ff);

   // Sequence one word: store access, reads, math, result hand-off
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      rd_idx_in      = rd_idx_ff;
      pend_status_in = pend_status_ff;
      pend_eval_in   = pend_eval_ff;
      store_en       = 1'b0;
      store_we       = 1'b0;
      store_addr     = rd_sum[ADDR_W-1:0];
      rsp_load       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            rd_idx_in = '0;
            if (req_accept) begin
               if (req_command == CMD_APPEND) begin
                  pend_eval_in = 1'b0;
                  state_in     = S_DONE;
                  if (store_full) begin
                     pend_status_in = ST_FULL;
                  end else begin
                     pend_status_in = ST_OK;
                     store_en       = 1'b1;
                     store_we       = 1'b1;
                     store_addr     = cnt_ff[ADDR_W-1:0];
                     cnt_in         = cnt_ff + CNT_W'(1);
                  end
               end else if (seg_ok) begin
                  pend_eval_in   = 1'b1;
                  pend_status_in = ST_OK;
                  state_in       = S_READ;
               end else begin
                  pend_eval_in   = 1'b0;
                  pend_status_in = ST_RANGE;
                  state_in       = S_DONE;
               end
            end
         end
         S_READ: begin
            store_en  = 1'b1;
            rd_idx_in = rd_idx_ff + TAP_IDX_W'(1);
            if (rd_idx_ff == TAP_IDX_W'(TAPS - 1)) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (x_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rd_idx_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         rd_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_eval_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_idx_ff    <= rd_idx_in;
         rd_valid_ff  <= (state_ff == S_READ);
         rd_last_ff   <= (state_ff == S_READ) && (rd_idx_ff == TAP_IDX_W'(TAPS - 1));
         rsp_valid_ff <= rsp_valid_in;
         pend_eval_ff <= pend_eval_in;
      end
   end

   // Hold the word's operands and pending status
   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      if (req_accept) begin
         seg_ff  <= req_segment;
         frac_ff <= frac_ext[FB-1:0];
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff  <= pend_status_ff;
         rsp_curve_x_ff <= pend_eval_ff ? x_result : '0;
         rsp_curve_y_ff <= pend_eval_ff ? y_result : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_curve_x = rsp_curve_x_ff;
   assign rsp_curve_y = rsp_curve_y_ff;
   assign rsp_status  = rsp_status_ff;

   assign shift_ctrl.shift = rd_valid_ff;
   assign shift_ctrl.last  = rd_last_ff;

   crse_store #(
      .DEPTH  (MAX_POINTS),
      .DATA_W (WORD_W)
   ) u_store (
      .clock (clock),
      .en    (store_en),
      .we    (store_we),
      .addr  (store_addr),
      .wdata ({req_point_x, req_point_y}),
      .rdata (store_rdata)
   );

   crse_axis #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_axis_x (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (shift_ctrl),
      .word   (store_rdata[WORD_W-1:POINT_W]),
      .frac   (frac_ff),
      .result (x_result),
      .done   (x_done)
   );

   crse_axis #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_axis_y (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (shift_ctrl),
      .word   (store_rdata[POINT_W-1:0]),
      .frac   (frac_ff),
      .result (y_result),
      .done   (y_done)
   );

   // Checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond capacity");

   a_axes_lockstep: assert property (@(posedge clock) disable iff (reset)
      x_done == y_done)
      else $error("axis pipelines out of step");

   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      x_done |-> state_ff == S_CALC)
      else $error("axis result outside calc phase");

   a_eval_reads: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_command == CMD_EVAL && seg_ok) |=> state_ff == S_READ)
      else $error("in-range evaluate did not start reads");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && slot_free) |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("result not handed to output register");

endmodule : catmull_rom_spline_eval
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the Catmull-Rom spline evaluator
// Drives append and evaluate words with random gaps and a stalling result
// sink. A scoreboard keeps its own copy of the point store, works out the
// exact curve point for each accepted word and checks every result word
// field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
   import crse_pkg::*;

   localparam int MAX_POINTS = 64;
   localparam int FRAC_BITS  = 12;
   localparam longint ONE    = longint'(1) << FRAC_BITS;
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_WORDS = 800;

   typedef struct {
      logic signed [POINT_W-1:0] curve_x;
      logic signed [POINT_W-1:0] curve_y;
      status_type                status;
   } curve_result_type;

   // Shadow point store and the queue of curve points still to come
   class spline_scoreboard;
      logic signed [POINT_W-1:0] x_pts [MAX_POINTS];
      logic signed [POINT_W-1:0] y_pts [MAX_POINTS];
      int unsigned               point_count;
      curve_result_type          curve_q [$];
      int                        errors;

      function new();
         point_count = 0;
         errors      = 0;
      endfunction

      // Exact blend of four taps, halved, rounded half up, saturated
      function logic signed [POINT_W-1:0] blend_axis(longint p0, longint p1,
                                                     longint p2, longint p3,
                                                     longint f);
         longint a, b, c, d, sum, q, r, u, w, v;
         a   = 2 * p1;
         b   = p2 - p0;
         c   = 2 * p0 - 5 * p1 + 4 * p2 - p3;
         d   = 3 * p1 - p0 - 3 * p2 + p3;
         sum = (d * f + c * ONE) * f + b * ONE * ONE;
         q   = sum >>> FRAC_BITS;
         r   = sum - q * ONE;
         u   = q * f + ((r * f) >>> FRAC_BITS);
         w   = a * ONE * ONE + u;
         v   = (w + ONE * ONE) >>> (2 * FRAC_BITS + 1);
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         return v[POINT_W-1:0];
      endfunction

      // Note an accepted request word and queue its curve point
      function void note_word(logic cmd, logic signed [POINT_W-1:0] px,
                              logic signed [POINT_W-1:0] py,
                              logic [SEG_W-1:0] seg, logic [FRAC_IN_W-1:0] frac);
         curve_result_type res;
         int unsigned      s;
         res.curve_x = '0;
         res.curve_y = '0;
         res.status  = ST_OK;
         s = seg;
         if (cmd == CMD_APPEND) begin
            if (point_count >= MAX_POINTS) begin
               res.status = ST_FULL;
            end else begin
               x_pts[point_count] = px;
               y_pts[point_count] = py;
               point_count++;
            end
         end else if (s + 3 >= point_count) begin
            res.status = ST_RANGE;
         end else begin
            res.curve_x = blend_axis(x_pts[s], x_pts[s+1], x_pts[s+2], x_pts[s+3],
                                     longint'(frac));
            res.curve_y = blend_axis(y_pts[s], y_pts[s+1], y_pts[s+2], y_pts[s+3],
                                     longint'(frac));
         end
         curve_q = {curve_q, res};
      endfunction

      // Check one result word against the oldest queued curve point
      function void check_word(logic signed [POINT_W-1:0] cx,
                               logic signed [POINT_W-1:0] cy,
                               logic [STATUS_W-1:0] st);
         curve_result_type e;
         if (curve_q.size() == 0) begin
            $error("result word with nothing queued: x %0d y %0d status %0d",
                   cx, cy, st);
            errors++;
            return;
         end
         e = curve_q.pop_front();
         if (st !== e.status) begin
            $error("status mismatch: expected %0d, actual %0d", e.status, st);
            errors++;
         end
         if (cx !== e.curve_x) begin
            $error("curve_x mismatch: expected %0d, actual %0d", e.curve_x, cx);
            errors++;
         end
         if (cy !== e.curve_y) begin
            $error("curve_y mismatch: expected %0d, actual %0d", e.curve_y, cy);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;

   logic                         req_valid    = 1'b0;
   logic                         req_ready;
   logic                         req_command  = CMD_APPEND;
   logic signed [POINT_W-1:0]    req_point_x  = '0;
   logic signed [POINT_W-1:0]    req_point_y  = '0;
   logic        [SEG_W-1:0]      req_segment  = '0;
   logic        [FRAC_IN_W-1:0]  req_fraction = '0;
   logic                         rsp_valid;
   logic                         rsp_ready    = 1'b0;
   logic signed [POINT_W-1:0]    rsp_curve_x;
   logic signed [POINT_W-1:0]    rsp_curve_y;
   logic        [STATUS_W-1:0]   rsp_status;

   spline_scoreboard sb = new();

   catmull_rom_spline_eval #(
      .MAX_POINTS    (MAX_POINTS),
      .FRACTION_BITS (FRAC_BITS)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_segment  (req_segment),
      .req_fraction (req_fraction),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_curve_x  (rsp_curve_x),
      .rsp_curve_y  (rsp_curve_y),
      .rsp_status   (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then long
   function automatic int pick_gap(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Coordinate: extremes now and then, otherwise any 16-bit value
   function automatic logic signed [POINT_W-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         default: return POINT_W'($urandom());
      endcase
   endfunction

   bit req_calm = 1'b0;

   // Offer one request word after a random gap and hold it until accepted
   task automatic send_word(input logic cmd, input logic signed [POINT_W-1:0] px,
                            input logic signed [POINT_W-1:0] py,
                            input logic [SEG_W-1:0] seg,
                            input logic [FRAC_IN_W-1:0] frac);
      int gap;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_point_x  <= px;
      req_point_y  <= py;
      req_segment  <= seg;
      req_fraction <= frac;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note_word(cmd, px, py, seg, frac);
   endtask

   task automatic append_point(input logic signed [POINT_W-1:0] px,
                               input logic signed [POINT_W-1:0] py);
      send_word(CMD_APPEND, px, py, SEG_W'($urandom()), FRAC_IN_W'($urandom()));
   endtask

   task automatic eval_point(input logic [SEG_W-1:0] seg,
                             input logic [FRAC_IN_W-1:0] frac);
      send_word(CMD_EVAL, POINT_W'($urandom()), POINT_W'($urandom()), seg, frac);
   endtask

   // Result sink: check accepted words, stall at random
   int  stall_left  = 0;
   int  sink_cycles = 0;
   bit  sink_calm   = 1'b0;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word(rsp_curve_x, rsp_curve_y, rsp_status);
      sink_cycles++;
      sink_calm = ((sink_cycles / 500) % 3) == 2;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready  <= 1'b1;
         stall_left = pick_gap(sink_calm);
      end
   end

   // Watchdog: end the run if no word moves for too long
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      int r;
      int cnt;
      int seg;
      logic [FRAC_IN_W-1:0] frac;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: evaluate on an empty store
      eval_point(0, 0);
      // Extreme taps that overshoot both ways
      append_point(16'sh8000, 16'sh7FFF);
      append_point(16'sh7FFF, 16'sh8000);
      append_point(16'sh7FFF, 16'sh8000);
      append_point(16'sh8000, 16'sh7FFF);
      eval_point(0, 0);
      eval_point(0, 12'hFFF);
      eval_point(0, 12'h800);
      eval_point(0, 12'h001);
      eval_point(0, 12'h400);
      // First segment past the end
      eval_point(1, 12'h800);
      append_point(16'sh0000, 16'sh0000);
      append_point(-16'sd1, 16'sd1);
      eval_point(1, 12'h800);
      eval_point(2, 12'hFFF);
      eval_point(2, 12'h555);
      eval_point(3, 12'h000);
      eval_point(63, 12'hFFF);

      // Random: fill the store while evaluating, then keep hitting it full
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         req_calm = ((i / 100) % 3) == 1;
         cnt = sb.point_count;
         r = $urandom_range(0, 99);
         if ((cnt < MAX_POINTS && r < 40) || (cnt >= MAX_POINTS && r < 10)) begin
            append_point(pick_coord(), pick_coord());
         end else begin
            r = $urandom_range(0, 99);
            if (cnt >= 4 && r < 75)
               seg = $urandom_range(0, cnt - 4);
            else if (cnt >= 4 && r < 82)
               seg = cnt - 4;
            else if (cnt >= 3 && cnt - 3 < 64 && r < 90)
               seg = cnt - 3;
            else
               seg = $urandom_range(0, 63);
            case ($urandom_range(0, 19))
               0: frac = '0;
               1: frac = '1;
               2: frac = 12'h800;
               3: frac = 12'h001;
               default: frac = FRAC_IN_W'($urandom());
            endcase
            eval_point(seg[SEG_W-1:0], frac);
         end
      end
      req_valid <= 1'b0;

      // Drain outstanding results, then watch for strays
      while (sb.curve_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.curve_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/crse_pkg.sv
hdl/crse_store.sv
hdl/crse_axis.sv
hdl/catmull_rom_spline_eval.sv
verif/tb_top.sv
